[hdl/rrq_pkg.sv]
// ----------------------------------------------------------------------------
// rrq_pkg
// Shared types and codes for the round-robin run queue.
// ----------------------------------------------------------------------------
package rrq_pkg;

    localparam int THREADS = 64;
    localparam int SLOT_W  = $clog2(THREADS);
    localparam int LINK_W  = $clog2(THREADS + 1);
    localparam int CNT_W   = $clog2(THREADS + 1);

    localparam logic [LINK_W-1:0] NIL_LINK = LINK_W'(THREADS);

    // operation modes
    localparam logic [2:0] MODE_ADD    = 3'd0;
    localparam logic [2:0] MODE_REMOVE = 3'd1;
    localparam logic [2:0] MODE_SLEEP  = 3'd2;
    localparam logic [2:0] MODE_WAKE   = 3'd3;
    localparam logic [2:0] MODE_PICK   = 3'd4;
    localparam logic [2:0] MODE_SET    = 3'd5;

    // result status
    localparam logic [1:0] STAT_DONE  = 2'd0;
    localparam logic [1:0] STAT_SKIP  = 2'd1;
    localparam logic [1:0] STAT_EMPTY = 2'd2;

    // run states
    localparam logic [1:0] RS_RUNNABLE   = 2'd0;
    localparam logic [1:0] RS_INT_SLEEP  = 2'd1;
    localparam logic [1:0] RS_UNINT_SLEEP = 2'd2;

    typedef struct packed {
        logic [LINK_W-1:0] nxt;
        logic [LINK_W-1:0] prv;
        logic [1:0]        run_st;
        logic              queued;
    } entry_t;

    localparam entry_t RESET_ENTRY = '{nxt: NIL_LINK, prv: NIL_LINK,
                                       run_st: RS_RUNNABLE, queued: 1'b0};

endpackage

[hdl/round_robin_run_queue.sv]
// ----------------------------------------------------------------------------
// round_robin_run_queue
// Thread run queue as a doubly linked list in a slot table, with round-robin
// pick of the next runnable thread.
// ----------------------------------------------------------------------------
// A queue update steps from S_EVAL through S_FIX_P, S_FIX_N or S_TAIL and S_WR_T as
// needed to S_RESP; a pick walks one slot per S_WALK step, at most 64 slots.
// One transaction at a time; the slot table has one read and one write port,
// and each list step is one read-modify-write of that table.
// Reset: synchronous, active low; slot entries read as unlinked and runnable
// through per-entry valid bits, so no clearing pass is needed.
module round_robin_run_queue (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // thread_id[5:0], current_id[11:6], new_state[13:12]
    input  logic [3:0]  s_tuser,   // mode[2:0], current_valid[3]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // chosen_id[5:0], queue_count[12:6]
    output logic [2:0]  m_tuser    // status[1:0], choose_idle[2]
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_EVAL  = 4'd1;
    localparam logic [3:0] S_FIX_P = 4'd2;
    localparam logic [3:0] S_FIX_N = 4'd3;
    localparam logic [3:0] S_TAIL  = 4'd4;
    localparam logic [3:0] S_WR_T  = 4'd5;
    localparam logic [3:0] S_WALK  = 4'd6;
    localparam logic [3:0] S_RESP  = 4'd7;

    localparam int SW = rrq_pkg::SLOT_W;
    localparam int LW = rrq_pkg::LINK_W;
    localparam int CW = rrq_pkg::CNT_W;

    rrq_pkg::entry_t slot_mem [rrq_pkg::THREADS];
    rrq_pkg::entry_t rd_raw_reg;
    logic            rd_vld_reg;
    logic [rrq_pkg::THREADS-1:0] vld_reg;

    logic [3:0]    state_reg, state_next;
    logic [2:0]    mode_reg;
    logic [SW-1:0] tid_reg;
    logic          cur_valid_reg;
    logic [1:0]    ns_reg;
    logic [LW-1:0] head_reg, head_next;
    logic [LW-1:0] tail_reg, tail_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] checked_reg, checked_next;
    logic [SW-1:0] cand_reg, cand_next;
    logic [LW-1:0] p_reg, p_next;
    logic [LW-1:0] n_reg, n_next;
    logic          hd_reg, hd_next;
    logic          tl_reg, tl_next;
    rrq_pkg::entry_t twr_reg, twr_next;
    logic [1:0]    status_reg, status_next;
    logic [SW-1:0] chosen_reg, chosen_next;
    logic          idle_reg, idle_next;

    logic          out_valid_reg;
    logic [1:0]    out_status_reg;
    logic [SW-1:0] out_chosen_reg;
    logic          out_idle_reg;
    logic [CW-1:0] out_count_reg;

    logic            accept;
    logic [SW-1:0]   rd_addr;
    logic            mem_we;
    logic [SW-1:0]   mem_waddr;
    rrq_pkg::entry_t mem_wdata;
    rrq_pkg::entry_t rd_entry;
    logic            linked;
    logic            head_nil;
    logic [LW-1:0]   walk_link;

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign rd_entry = rd_vld_reg ? rd_raw_reg : rrq_pkg::RESET_ENTRY;
    assign linked   = rd_entry.queued || (rd_entry.nxt != rrq_pkg::NIL_LINK)
                      || (rd_entry.prv != rrq_pkg::NIL_LINK);
    assign head_nil = (head_reg >= rrq_pkg::NIL_LINK);
    assign walk_link = (rd_entry.nxt >= rrq_pkg::NIL_LINK) ? head_reg : rd_entry.nxt;

    // slot table
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            slot_mem[mem_waddr] <= mem_wdata;
        end
        rd_raw_reg <= slot_mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end else begin
            if (mem_we) begin
                vld_reg[mem_waddr] <= 1'b1;
            end
            rd_vld_reg <= vld_reg[rd_addr];
        end
    end

    always_comb begin
        state_next   = state_reg;
        head_next    = head_reg;
        tail_next    = tail_reg;
        count_next   = count_reg;
        checked_next = checked_reg;
        cand_next    = cand_reg;
        p_next       = p_reg;
        n_next       = n_reg;
        hd_next      = hd_reg;
        tl_next      = tl_reg;
        twr_next     = twr_reg;
        status_next  = status_reg;
        chosen_next  = chosen_reg;
        idle_next    = idle_reg;
        rd_addr      = tid_reg;
        mem_we       = 1'b0;
        mem_waddr    = tid_reg;
        mem_wdata    = twr_reg;

        case (state_reg)
            S_IDLE: begin
                rd_addr = (s_tuser[2:0] == rrq_pkg::MODE_PICK) ? s_tdata[11:6]
                                                                : s_tdata[5:0];
                if (accept) begin
                    state_next = S_EVAL;
                end
            end
            S_EVAL: begin
                status_next = rrq_pkg::STAT_SKIP;
                chosen_next = '0;
                idle_next   = 1'b0;
                state_next  = S_RESP;
                twr_next    = rd_entry;
                case (mode_reg)
                    rrq_pkg::MODE_ADD, rrq_pkg::MODE_WAKE: begin
                        if (mode_reg == rrq_pkg::MODE_WAKE) begin
                            if (rd_entry.run_st == rrq_pkg::RS_INT_SLEEP ||
                                rd_entry.run_st == rrq_pkg::RS_UNINT_SLEEP) begin
                                status_next     = rrq_pkg::STAT_DONE;
                                twr_next.run_st = rrq_pkg::RS_RUNNABLE;
                                state_next      = S_WR_T;
                            end
                        end else if (!linked) begin
                            status_next = rrq_pkg::STAT_DONE;
                        end
                        if (!linked && status_next == rrq_pkg::STAT_DONE) begin
                            twr_next.nxt    = rrq_pkg::NIL_LINK;
                            twr_next.prv    = head_nil ? rrq_pkg::NIL_LINK : tail_reg;
                            twr_next.queued = 1'b1;
                            head_next       = head_nil ? {1'b0, tid_reg} : head_reg;
                            tail_next       = {1'b0, tid_reg};
                            count_next      = count_reg + 1'b1;
                            p_next          = tail_reg;
                            if (!head_nil && tail_reg < rrq_pkg::NIL_LINK) begin
                                rd_addr    = tail_reg[SW-1:0];
                                state_next = S_TAIL;
                            end else begin
                                state_next = S_WR_T;
                            end
                        end
                    end
                    rrq_pkg::MODE_REMOVE, rrq_pkg::MODE_SLEEP: begin
                        if (mode_reg == rrq_pkg::MODE_SLEEP) begin
                            twr_next.run_st = rrq_pkg::RS_INT_SLEEP;
                            state_next      = S_WR_T;
                        end
                        if (count_reg == '0) begin
                            status_next = rrq_pkg::STAT_EMPTY;
                        end else if (rd_entry.queued) begin
                            status_next     = rrq_pkg::STAT_DONE;
                            twr_next.nxt    = rrq_pkg::NIL_LINK;
                            twr_next.prv    = rrq_pkg::NIL_LINK;
                            twr_next.queued = 1'b0;
                            p_next          = rd_entry.prv;
                            n_next          = rd_entry.nxt;
                            hd_next         = (head_reg == {1'b0, tid_reg});
                            tl_next         = (tail_reg == {1'b0, tid_reg});
                            if (head_reg == {1'b0, tid_reg}) begin
                                head_next = rd_entry.nxt;
                            end
                            if (tail_reg == {1'b0, tid_reg}) begin
                                tail_next = rd_entry.prv;
                            end
                            count_next = count_reg - 1'b1;
                            if (rd_entry.prv < rrq_pkg::NIL_LINK) begin
                                rd_addr    = rd_entry.prv[SW-1:0];
                                state_next = S_FIX_P;
                            end else if (rd_entry.nxt < rrq_pkg::NIL_LINK) begin
                                rd_addr    = rd_entry.nxt[SW-1:0];
                                state_next = S_FIX_N;
                            end else begin
                                state_next = S_WR_T;
                            end
                        end
                    end
                    rrq_pkg::MODE_SET: begin
                        status_next     = rrq_pkg::STAT_DONE;
                        twr_next.run_st = ns_reg;
                        state_next      = S_WR_T;
                    end
                    rrq_pkg::MODE_PICK: begin
                        status_next = rrq_pkg::STAT_DONE;
                        if (count_reg == '0 || head_nil) begin
                            idle_next = 1'b1;
                        end else if (!cur_valid_reg) begin
                            chosen_next = head_reg[SW-1:0];
                        end else begin
                            checked_next = '0;
                            cand_next    = walk_link[SW-1:0];
                            rd_addr      = walk_link[SW-1:0];
                            state_next   = S_WALK;
                        end
                    end
                    default: begin
                        status_next = rrq_pkg::STAT_SKIP;
                    end
                endcase
            end
            S_FIX_P: begin
                mem_we        = 1'b1;
                mem_waddr     = p_reg[SW-1:0];
                mem_wdata     = rd_entry;
                mem_wdata.nxt = tl_reg ? rrq_pkg::NIL_LINK : n_reg;
                if (n_reg < rrq_pkg::NIL_LINK) begin
                    rd_addr    = n_reg[SW-1:0];
                    state_next = S_FIX_N;
                end else begin
                    state_next = S_WR_T;
                end
            end
            S_FIX_N: begin
                mem_we        = 1'b1;
                mem_waddr     = n_reg[SW-1:0];
                mem_wdata     = rd_entry;
                mem_wdata.prv = hd_reg ? rrq_pkg::NIL_LINK : p_reg;
                state_next    = S_WR_T;
            end
            S_TAIL: begin
                mem_we        = 1'b1;
                mem_waddr     = p_reg[SW-1:0];
                mem_wdata     = rd_entry;
                mem_wdata.nxt = {1'b0, tid_reg};
                state_next    = S_WR_T;
            end
            S_WR_T: begin
                mem_we     = 1'b1;
                mem_waddr  = tid_reg;
                mem_wdata  = twr_reg;
                state_next = S_RESP;
            end
            S_WALK: begin
                if (rd_entry.run_st == rrq_pkg::RS_RUNNABLE) begin
                    chosen_next = cand_reg;
                    state_next  = S_RESP;
                end else begin
                    checked_next = checked_reg + 1'b1;
                    if (checked_reg + 1'b1 == count_reg) begin
                        idle_next  = 1'b1;
                        state_next = S_RESP;
                    end else begin
                        cand_next = walk_link[SW-1:0];
                        rd_addr   = walk_link[SW-1:0];
                    end
                end
            end
            S_RESP: begin
                if (!out_valid_reg || m_tready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            head_reg      <= rrq_pkg::NIL_LINK;
            tail_reg      <= rrq_pkg::NIL_LINK;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
            if (state_reg == S_RESP && (!out_valid_reg || m_tready)) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            mode_reg      <= s_tuser[2:0];
            cur_valid_reg <= s_tuser[3];
            tid_reg       <= s_tdata[5:0];
            ns_reg        <= s_tdata[13:12];
        end
        checked_reg <= checked_next;
        cand_reg    <= cand_next;
        p_reg       <= p_next;
        n_reg       <= n_next;
        hd_reg      <= hd_next;
        tl_reg      <= tl_next;
        twr_reg     <= twr_next;
        status_reg  <= status_next;
        chosen_reg  <= chosen_next;
        idle_reg    <= idle_next;
        if (state_reg == S_RESP && (!out_valid_reg || m_tready)) begin
            out_status_reg <= status_reg;
            out_chosen_reg <= chosen_reg;
            out_idle_reg   <= idle_reg;
            out_count_reg  <= count_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, out_count_reg, out_chosen_reg};
    assign m_tuser  = {out_idle_reg, out_status_reg};

`ifndef SYNTH
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(rrq_pkg::THREADS))
        else $error("queue count out of range");

    a_head_count: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_IDLE |-> (head_reg == rrq_pkg::NIL_LINK) == (count_reg == '0))
        else $error("head and count disagree");

    a_walk_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_WALK |-> checked_reg < count_reg)
        else $error("pick walk past queue length");

    a_fix_distinct: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_FIX_P && n_reg < rrq_pkg::NIL_LINK |-> p_reg != n_reg)
        else $error("neighbors of removed slot coincide");

    a_idle_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[2] |-> m_tdata[5:0] == '0)
        else $error("idle pick with nonzero slot");
`endif

endmodule
